FILE: hdl/lchs_pkg.sv
// Shared constants and types for the linear-to-CHS address converter.
`timescale 1ns / 1ps

package lchs_pkg;

  // Defaults
  localparam int SECTOR_BYTES_DEF = 512;
  localparam int DIV_STEP         = 4;    // quotient bits resolved per divider stage

  // Field widths
  localparam int OFFSET_W = 31;
  localparam int LIN_W    = 32;
  localparam int SPT_W    = 6;
  localparam int HEADS_W  = 8;
  localparam int CYLS_W   = 11;
  localparam int PART_W   = 31;
  localparam int DRIVE_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Register reset values
  localparam logic [SPT_W-1:0]   SPT_RST   = 6'd63;
  localparam logic [HEADS_W-1:0] HEADS_RST = 8'd255;
  localparam logic [CYLS_W-1:0]  CYLS_RST  = 11'd1024;
  localparam logic [PART_W-1:0]  PART_RST  = '0;
  localparam logic [DRIVE_W-1:0] DRIVE_RST = 8'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPT   = 3'd0,
    CFG_HEADS = 3'd1,
    CFG_CYLS  = 3'd2,
    CFG_PART  = 3'd3,
    CFG_DRIVE = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CYL_BIG   = 2'd1,
    ST_MEDIA_END = 2'd2
  } status_t;

endpackage

FILE: hdl/lchs_div.sv
// Pipelined restoring divider, DIV_STEP quotient bits per stage, with sideband.
`timescale 1ns / 1ps

module lchs_div #(
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 8,
  parameter int SIDE_W = 1,
  parameter int STEP   = lchs_pkg::DIV_STEP
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [SIDE_W-1:0] in_side,
  input  logic [DEN_W-1:0]  den,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [NUM_W-1:0]  out_quot,
  output logic [DEN_W-1:0]  out_rem,
  output logic [SIDE_W-1:0] out_side
);

  localparam int STAGES = (NUM_W + STEP - 1) / STEP;
  localparam int PAD_W  = STAGES * STEP;

  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] en;
  logic [STAGES-1:0] v_src;
  logic [PAD_W-1:0]  q_r      [STAGES];
  logic [DEN_W-1:0]  rem_r    [STAGES];
  logic [SIDE_W-1:0] side_r   [STAGES];
  logic [PAD_W-1:0]  q_src    [STAGES];
  logic [DEN_W-1:0]  r_src    [STAGES];
  logic [SIDE_W-1:0] s_src    [STAGES];
  logic [PAD_W-1:0]  q_nxt    [STAGES];
  logic [DEN_W-1:0]  rem_nxt  [STAGES];

  // A stage may load when it is empty or its successor loads too.
  always_comb begin
    en[STAGES-1] = ~vld_r[STAGES-1] | out_ready;
    for (int s = STAGES - 2; s >= 0; s--) begin
      en[s] = ~vld_r[s] | en[s+1];
    end
  end

  assign in_ready = en[0];

  // First stage loads from the ports, the others from the stage before.
  always_comb begin
    q_src[0] = PAD_W'(in_num);
    r_src[0] = '0;
    v_src[0] = in_valid;
    s_src[0] = in_side;
    for (int s = 1; s < STAGES; s++) begin
      q_src[s] = q_r[s-1];
      r_src[s] = rem_r[s-1];
      v_src[s] = vld_r[s-1];
      s_src[s] = side_r[s-1];
    end
  end

  // Dividend bits shift out the top while quotient bits shift in below.
  always_comb begin
    logic [DEN_W:0]   trial;
    logic [PAD_W-1:0] q;
    logic [DEN_W-1:0] r;
    for (int s = 0; s < STAGES; s++) begin
      q     = q_src[s];
      r     = r_src[s];
      trial = '0;
      for (int k = 0; k < STEP; k++) begin
        trial = {r, q[PAD_W-1]};
        q     = {q[PAD_W-2:0], 1'b0};
        if (trial >= {1'b0, den}) begin
          trial = trial - {1'b0, den};
          q[0]  = 1'b1;
        end
        r = trial[DEN_W-1:0];
      end
      q_nxt[s]   = q;
      rem_nxt[s] = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int s = 0; s < STAGES; s++) begin
        if (en[s]) begin
          vld_r[s] <= v_src[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < STAGES; s++) begin
      if (en[s] && v_src[s]) begin
        q_r[s]    <= q_nxt[s];
        rem_r[s]  <= rem_nxt[s];
        side_r[s] <= s_src[s];
      end
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_quot  = q_r[STAGES-1][NUM_W-1:0];
  assign out_rem   = rem_r[STAGES-1];
  assign out_side  = side_r[STAGES-1];

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rem < den))
    else $error("divider remainder not below divisor");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&vld_r))
    else $error("divider refused input with a free stage");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted transfer missing from first stage");

endmodule

FILE: hdl/linear_to_chs_address.sv
// Top level: byte offset to BIOS cylinder/head/sector address converter.
`timescale 1ns / 1ps

// Takes one byte offset per cycle and returns one packed CHS result per offset, in order.
// SECTOR_BYTES must be a power of two: the byte offset is shifted down to a sector number
// and the partition start is added in one register stage. The path is that add stage,
// two pipelined restoring dividers (by sectors per track, by head count) and one output
// register. Every divider stage resolves DIV_STEP quotient bits, so throughput is one
// item per clock; a stalled output fills empty stages before it holds off the input.
// Configuration (index 0 sectors per track, 1 heads, 2 cylinders, 3 partition start,
// 4 drive) is taken at any time but must only change while no transfer is in flight.
// A divisor of zero acts as 1.
module linear_to_chs_address #(
  parameter int SECTOR_BYTES = lchs_pkg::SECTOR_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lchs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lchs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lchs_pkg::OFFSET_W-1:0]   in_byte_offset,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [7:0]                      out_drive,
  output logic [7:0]                      out_head,
  output logic [7:0]                      out_track_low,
  output logic [7:0]                      out_sector_packed,
  output logic                            out_sector_count
);

  localparam int SB_SHIFT = $clog2(SECTOR_BYTES);

  // Configuration registers
  logic [lchs_pkg::SPT_W-1:0]   spt_r;
  logic [lchs_pkg::HEADS_W-1:0] heads_r;
  logic [lchs_pkg::CYLS_W-1:0]  cyls_r;
  logic [lchs_pkg::PART_W-1:0]  part_r;
  logic [lchs_pkg::DRIVE_W-1:0] drive_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r   <= lchs_pkg::SPT_RST;
      heads_r <= lchs_pkg::HEADS_RST;
      cyls_r  <= lchs_pkg::CYLS_RST;
      part_r  <= lchs_pkg::PART_RST;
      drive_r <= lchs_pkg::DRIVE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lchs_pkg::CFG_SPT:   spt_r   <= cfg_data[lchs_pkg::SPT_W-1:0];
        lchs_pkg::CFG_HEADS: heads_r <= cfg_data[lchs_pkg::HEADS_W-1:0];
        lchs_pkg::CFG_CYLS:  cyls_r  <= cfg_data[lchs_pkg::CYLS_W-1:0];
        lchs_pkg::CFG_PART:  part_r  <= cfg_data[lchs_pkg::PART_W-1:0];
        lchs_pkg::CFG_DRIVE: drive_r <= cfg_data[lchs_pkg::DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [lchs_pkg::SPT_W-1:0]   spt_div;
  logic [lchs_pkg::HEADS_W-1:0] heads_div;

  assign spt_div   = (spt_r == '0)   ? lchs_pkg::SPT_W'(1)   : spt_r;
  assign heads_div = (heads_r == '0) ? lchs_pkg::HEADS_W'(1) : heads_r;

  // Byte offset -> sector number, plus partition start
  logic                       add_vld_r;
  logic [lchs_pkg::LIN_W-1:0] add_lin_r;
  logic                       d2_ready;

  assign in_ready = ~add_vld_r | d2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_vld_r <= 1'b0;
    end else if (in_ready) begin
      add_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      add_lin_r <= lchs_pkg::LIN_W'(in_byte_offset >> SB_SHIFT) + lchs_pkg::LIN_W'(part_r);
    end
  end

  // Sector number -> track number, sector within track
  logic                       d2_valid;
  logic                       d3_ready;
  logic [lchs_pkg::LIN_W-1:0] d2_quot;
  logic [lchs_pkg::SPT_W-1:0] d2_rem;
  logic                       d2_tag;

  lchs_div #(
    .NUM_W  (lchs_pkg::LIN_W),
    .DEN_W  (lchs_pkg::SPT_W),
    .SIDE_W (1)
  ) u_div_spt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (add_vld_r),
    .in_ready  (d2_ready),
    .in_num    (add_lin_r),
    .in_side   (1'b1),
    .den       (spt_div),
    .out_valid (d2_valid),
    .out_ready (d3_ready),
    .out_quot  (d2_quot),
    .out_rem   (d2_rem),
    .out_side  (d2_tag)
  );

  // Track number -> cylinder, head; sector rides along
  logic                         d3_valid;
  logic                         d3_out_ready;
  logic [lchs_pkg::LIN_W-1:0]   cyl;
  logic [lchs_pkg::HEADS_W-1:0] head;
  logic [lchs_pkg::SPT_W-1:0]   sec0;

  lchs_div #(
    .NUM_W  (lchs_pkg::LIN_W),
    .DEN_W  (lchs_pkg::HEADS_W),
    .SIDE_W (lchs_pkg::SPT_W)
  ) u_div_heads (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d2_valid),
    .in_ready  (d3_ready),
    .in_num    (d2_quot),
    .in_side   (d2_rem),
    .den       (heads_div),
    .out_valid (d3_valid),
    .out_ready (d3_out_ready),
    .out_quot  (cyl),
    .out_rem   (head),
    .out_side  (sec0)
  );

  // Status and BIOS packing
  logic                     out_valid_r;
  lchs_pkg::status_t        status_nxt;
  logic [1:0]               status_r;
  logic [7:0]               drive_out_r;
  logic [7:0]               head_r;
  logic [7:0]               track_r;
  logic [7:0]               spack_r;
  logic [lchs_pkg::SPT_W-1:0] sec1;

  assign d3_out_ready = ~out_valid_r | out_ready;
  assign sec1         = sec0 + lchs_pkg::SPT_W'(1);   // remainder <= 62, no wrap

  always_comb begin
    priority if (|cyl[lchs_pkg::LIN_W-1:10]) begin
      status_nxt = lchs_pkg::ST_CYL_BIG;
    end else if ({1'b0, cyl[9:0]} >= cyls_r) begin
      status_nxt = lchs_pkg::ST_MEDIA_END;
    end else begin
      status_nxt = lchs_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (d3_out_ready) begin
      out_valid_r <= d3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d3_out_ready && d3_valid) begin
      status_r    <= status_nxt;
      drive_out_r <= drive_r;
      if (status_nxt == lchs_pkg::ST_OK) begin
        head_r  <= head;
        track_r <= cyl[7:0];
        spack_r <= {cyl[9:8], sec1};
      end else begin
        head_r  <= '0;
        track_r <= '0;
        spack_r <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_drive         = drive_out_r;
  assign out_head          = head_r;
  assign out_track_low     = track_r;
  assign out_sector_packed = spack_r;
  assign out_sector_count  = 1'b1;

  a_ok_sector_one_based: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == lchs_pkg::ST_OK)) |-> (out_sector_packed[5:0] != 6'd0))
    else $error("good address with sector zero");

  a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != lchs_pkg::ST_OK))
      |-> ((out_head == 8'd0) && (out_track_low == 8'd0) && (out_sector_packed == 8'd0)))
    else $error("error result with address fields set");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= lchs_pkg::ST_MEDIA_END))
    else $error("undefined status code");

  // valid bit and payload travel together through the first divider
  a_spt_tag: assert property (@(posedge clk) disable iff (!rst_n)
    d2_valid |-> d2_tag)
    else $error("sector divider output valid without loaded data");

endmodule
